[src/hashed_filter_table_lookup_unit_macros.svh]
// Assertion helpers shared by the lookup unit.
`ifndef HASHED_FILTER_TABLE_LOOKUP_UNIT_MACROS_SVH
`define HASHED_FILTER_TABLE_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HFTL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hftl: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HFTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hftl: next-cycle check failed");

`endif

[src/hftl_pkg.sv]
package hftl_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_ENABLE   = 2'd1,
    OP_DISABLE  = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_MID,
    ST_FIN,
    ST_DISP
  } state_e;

  localparam int unsigned HashW    = 32;
  localparam int unsigned LinkW    = 12;
  localparam int unsigned HandlerW = 32;
  localparam int unsigned CountW   = 11;
  localparam int unsigned SlotW    = 10;

  // One key table entry: sorted hash and its linked service
  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [LinkW-1:0] link;
  } key_entry_t;

  // One filter entry: enable mark and handler word
  typedef struct packed {
    logic                enable;
    logic [HandlerW-1:0] handler;
  } filter_entry_t;

endpackage

[src/hftl_key_table.sv]
module hftl_key_table #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  hftl_pkg::key_entry_t wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output hftl_pkg::key_entry_t rdata_o
);
  import hftl_pkg::*;

  key_entry_t mem_q [Depth];
  key_entry_t rdata_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/hftl_filter_store.sv]
module hftl_filter_store #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  hftl_pkg::filter_entry_t wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output hftl_pkg::filter_entry_t rdata_o
);
  import hftl_pkg::*;

  filter_entry_t mem_q [Depth];
  filter_entry_t rdata_q;

  // Write one service entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/hashed_filter_table_lookup_unit.sv]
// Hashed filter table lookup unit.
// Command channel: an item (op_i, slot_i, key_hash_i, service_index_i,
// handler_word_i) is taken at a rising edge with start_i high and busy_o low.
// Every item yields one result word, shown for one cycle with done_o high on
// status_o, intercept_o, handler_out_o and matched_service_o. The receiver
// cannot stall; it must take each word in the cycle it is shown.
// entry_count_i is written whenever entry_count_we_i is high; the user must
// raise it only while idle, the block itself does not enforce this.
// Per item:
//   load      busy_o stays low, loads can follow every cycle
//   dispatch  one filter store read (none when the service is out of range)
//   enable / disable  one key table read per cycle through the single read
//     port: first and last entry, one probe per halving step and a final
//     probe. A zero count answers without a search, with status_o high.
// Items run one at a time; busy_o is high while a search or dispatch runs.
// Reset: entry_count returns to 0 and the filter store is cleared by a pass over
// its SERVICE_LIMIT entries, one entry per cycle, with busy_o high; configuration
// writes are taken during the pass. The key table is not cleared.
`include "hashed_filter_table_lookup_unit_macros.svh"

module hashed_filter_table_lookup_unit #(
  parameter int unsigned TABLE_DEPTH   = 1024,
  parameter int unsigned SERVICE_LIMIT = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [1:0]                       op_i,
  input  logic [hftl_pkg::SlotW-1:0]       slot_i,
  input  logic [hftl_pkg::HashW-1:0]       key_hash_i,
  input  logic [hftl_pkg::LinkW-1:0]       service_index_i,
  input  logic [hftl_pkg::HandlerW-1:0]    handler_word_i,
  input  logic                             entry_count_we_i,
  input  logic [hftl_pkg::CountW-1:0]      entry_count_i,
  output logic                             done_o,
  output logic                             status_o,
  output logic                             intercept_o,
  output logic [hftl_pkg::HandlerW-1:0]    handler_out_o,
  output logic [hftl_pkg::LinkW-1:0]       matched_service_o
);
  import hftl_pkg::*;

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned FW = (SERVICE_LIMIT > 1) ? $clog2(SERVICE_LIMIT) : 1;
  localparam int unsigned CW = (IW + 1 > CountW) ? IW + 1 : CountW;
  localparam int unsigned SW = (IW + 1 > SlotW) ? IW + 1 : SlotW;
  localparam int unsigned VW = LinkW + 1;
  localparam logic signed [IW:0] OneS = (IW + 1)'(1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
  localparam logic [SW-1:0] DepthS = SW'(TABLE_DEPTH);
  localparam logic [VW-1:0] SvcLimit = VW'(SERVICE_LIMIT);
  localparam logic [FW-1:0] ClrLast = FW'(SERVICE_LIMIT - 1);

  state_e state_q, state_d;

  logic [CountW-1:0] entry_count_q;
  logic [FW-1:0]     clr_q;

  // Latched item
  op_e                 op_q;
  logic [HashW-1:0]    key_q;
  logic [HandlerW-1:0] handler_q;

  // Search bounds
  logic signed [IW:0] lo_q, hi_q, mid_q;
  logic signed [IW:0] lo_d, hi_d, mid_d;
  logic signed [IW:0] lo_n, hi_n, mid_n, diff_n;

  // Memory ports
  logic          key_we, key_re;
  logic [IW-1:0] key_waddr, key_raddr;
  key_entry_t    key_wdata, key_rdata;

  logic          flt_we, flt_re;
  logic [FW-1:0] flt_waddr, flt_raddr;
  filter_entry_t flt_wdata, flt_rdata;

  // Result registers
  logic                done_q, done_d;
  logic                status_q, status_d;
  logic                intercept_q, intercept_d;
  logic [HandlerW-1:0] handler_out_q, handler_out_d;
  logic [LinkW-1:0]    matched_q, matched_d;

  logic          accept;
  op_e           op_in;
  logic [CW-1:0] cnt_ext, cnt_eff;
  logic [SW-1:0] slot_ext;
  logic          slot_ok, svc_ok, link_ok;
  logic          key_eq, key_lt, key_gt;
  logic          hit, miss, upd;

  assign accept  = start_i && !busy_o;
  assign op_in   = op_e'(op_i);
  assign cnt_ext = CW'(entry_count_q);
  assign cnt_eff = (cnt_ext > DepthC) ? DepthC : cnt_ext;
  assign slot_ext = SW'(slot_i);
  assign slot_ok  = slot_ext < DepthS;
  assign svc_ok   = {1'b0, service_index_i} < SvcLimit;
  assign link_ok  = {1'b0, key_rdata.link} < SvcLimit;

  // Compare the probed entry with the key
  assign key_eq = key_rdata.hash == key_q;
  assign key_lt = key_rdata.hash < key_q;
  assign key_gt = key_rdata.hash > key_q;

  // Narrow bounds after a probe, then pick the next midpoint
  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (state_q == ST_MID) begin
      if (key_lt) begin
        lo_n = mid_q + OneS;
      end else begin
        hi_n = mid_q - OneS;
      end
    end
  end

  assign diff_n = hi_n - lo_n;
  assign mid_n  = lo_n + (diff_n >>> 1);

  // Hit and miss decisions per probe
  always_comb begin
    hit  = 1'b0;
    miss = 1'b0;
    case (state_q)
      ST_LO:  miss = key_gt;
      ST_HI: begin
        hit  = key_eq;
        miss = key_lt;
      end
      ST_MID: hit = key_eq;
      ST_FIN: begin
        hit  = key_eq;
        miss = !key_eq;
      end
      default: ;
    endcase
  end

  assign upd = hit && link_ok;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_ENABLE, OP_DISABLE: begin
              if (cnt_eff != '0) begin
                state_d = ST_LO;
              end
            end
            OP_DISPATCH: begin
              if (svc_ok) begin
                state_d = ST_DISP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LO:   state_d = miss ? ST_IDLE : ST_HI;
      ST_HI, ST_MID: begin
        if (hit || miss) begin
          state_d = ST_IDLE;
        end else if (lo_n < hi_n) begin
          state_d = ST_MID;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:  state_d = ST_IDLE;
      ST_DISP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: memory accesses, bounds and result word
  always_comb begin
    key_we    = 1'b0;
    key_waddr = slot_ext[IW-1:0];
    key_wdata = '{hash: key_hash_i, link: service_index_i};
    key_re    = 1'b0;
    key_raddr = '0;
    flt_re    = 1'b0;
    flt_raddr = service_index_i[FW-1:0];
    flt_we    = 1'b0;
    flt_waddr = key_rdata.link[FW-1:0];
    flt_wdata = '{enable: (op_q == OP_ENABLE), handler:
                  (op_q == OP_ENABLE) ? handler_q : '0};
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    done_d    = 1'b0;
    status_d  = 1'b0;
    intercept_d   = 1'b0;
    handler_out_d = '0;
    matched_d     = '0;
    case (state_q)
      ST_CLEAR: begin
        flt_we    = 1'b1;
        flt_waddr = clr_q;
        flt_wdata = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_LOAD: begin
              key_we = slot_ok;
              done_d = 1'b1;
            end
            OP_ENABLE, OP_DISABLE: begin
              lo_d   = '0;
              hi_d   = (IW + 1)'(cnt_eff - 1'b1);
              key_re = 1'b1;
              if (cnt_eff == '0) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end
            end
            OP_DISPATCH: begin
              flt_re = svc_ok;
              done_d = !svc_ok;
            end
            default: ;
          endcase
        end
      end
      ST_LO: begin
        key_re    = 1'b1;
        key_raddr = hi_q[IW-1:0];
      end
      ST_HI, ST_MID: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (!hit && !miss) begin
          key_re = 1'b1;
          if (lo_n < hi_n) begin
            mid_d     = mid_n;
            key_raddr = mid_n[IW-1:0];
          end else begin
            key_raddr = lo_n[IW-1:0];
          end
        end
      end
      ST_DISP: begin
        done_d = 1'b1;
        if (flt_rdata.enable && (flt_rdata.handler != '0)) begin
          intercept_d   = 1'b1;
          handler_out_d = flt_rdata.handler;
        end
      end
      default: ;
    endcase
    // Finish a search: report and update the filter entry on a hit with the link in range
    if (hit || miss) begin
      done_d    = 1'b1;
      status_d  = miss;
      matched_d = hit ? key_rdata.link : '0;
      flt_we    = upd;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      entry_count_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (entry_count_we_i) begin
        entry_count_q <= entry_count_i;
      end
    end
  end

  // Item, bounds and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_in;
      key_q     <= key_hash_i;
      handler_q <= handler_word_i;
    end
    lo_q          <= lo_d;
    hi_q          <= hi_d;
    mid_q         <= mid_d;
    status_q      <= status_d;
    intercept_q   <= intercept_d;
    handler_out_q <= handler_out_d;
    matched_q     <= matched_d;
  end

  hftl_key_table #(
    .Depth (TABLE_DEPTH),
    .AddrW (IW)
  ) u_key_table (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  hftl_filter_store #(
    .Depth (SERVICE_LIMIT),
    .AddrW (FW)
  ) u_filter_store (
    .clk_i   (clk_i),
    .we_i    (flt_we),
    .waddr_i (flt_waddr),
    .wdata_i (flt_wdata),
    .re_i    (flt_re),
    .raddr_i (flt_raddr),
    .rdata_o (flt_rdata)
  );

  assign busy_o            = state_q != ST_IDLE;
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign intercept_o       = intercept_q;
  assign handler_out_o     = handler_out_q;
  assign matched_service_o = matched_q;

  // Checks
  `HFTL_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start_i && !busy_o, busy_o || done_o)
  `HFTL_ASSERT_NOW(a_no_result_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !done_o)
  `HFTL_ASSERT_NOW(a_mid_bounds_ordered, clk_i, rst_ni, state_q == ST_MID, lo_q < hi_q)
  `HFTL_ASSERT_NOW(a_filter_write_in_range, clk_i, rst_ni, flt_we && state_q != ST_CLEAR, link_ok)

endmodule

[test/hashed_filter_table_lookup_unit_tb.sv]
module hashed_filter_table_lookup_unit_tb;
  import hftl_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 1024;
  localparam int unsigned SERVICE_LIMIT = 1024;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_ITEMS  = 1050;

  // One command word as the block takes it
  typedef struct packed {
    op_e                 op;
    logic [SlotW-1:0]    slot;
    logic [HashW-1:0]    key;
    logic [LinkW-1:0]    svc;
    logic [HandlerW-1:0] handler;
  } lookup_cmd_t;

  // One result word as the block shows it
  typedef struct packed {
    logic                status;
    logic                intercept;
    logic [HandlerW-1:0] handler;
    logic [LinkW-1:0]    service;
  } lookup_word_t;

  // Shadow key table and filter store; predicts each result word
  class filter_lookup_board;
    bit [HashW-1:0]    key_mem     [TABLE_DEPTH];
    bit [LinkW-1:0]    link_mem    [TABLE_DEPTH];
    bit [HandlerW-1:0] handler_mem [SERVICE_LIMIT];
    bit                enable_mem  [SERVICE_LIMIT];
    bit [CountW-1:0]   entry_count;
    lookup_word_t      pending_words[$];
    int unsigned       errors;

    function int searched_count();
      return (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
    endfunction

    // Binary search over the loaded slots, bounds checked first
    function bit find_key(input bit [HashW-1:0] key, output int found);
      int cnt, lo, hi, mid;
      cnt = searched_count();
      found = 0;
      if (cnt == 0) return 1'b0;
      lo = 0;
      hi = cnt - 1;
      if (key < key_mem[lo] || key > key_mem[hi]) return 1'b0;
      if (key == key_mem[hi]) begin
        found = hi;
        return 1'b1;
      end
      while (lo < hi) begin
        mid = (hi - lo) / 2 + lo;
        if (key_mem[mid] == key) begin
          found = mid;
          return 1'b1;
        end
        if (key_mem[mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
      found = lo;
      return key_mem[lo] == key;
    endfunction

    // Apply one accepted command and queue the word it must produce
    function void note_command(input lookup_cmd_t c);
      lookup_word_t    w;
      int              hit_slot;
      bit [LinkW-1:0]  link;
      w = '0;
      case (c.op)
        OP_LOAD: begin
          if (c.slot < TABLE_DEPTH) begin
            key_mem[c.slot]  = c.key;
            link_mem[c.slot] = c.svc;
          end
        end
        OP_ENABLE, OP_DISABLE: begin
          if (!find_key(c.key, hit_slot)) begin
            w.status = 1'b1;
          end else begin
            link = link_mem[hit_slot];
            w.service = link;
            if (link < SERVICE_LIMIT) begin
              handler_mem[link] = (c.op == OP_ENABLE) ? c.handler : '0;
              enable_mem[link]  = (c.op == OP_ENABLE);
            end
          end
        end
        default: begin
          if (c.svc < SERVICE_LIMIT && handler_mem[c.svc] != 0 && enable_mem[c.svc]) begin
            w.intercept = 1'b1;
            w.handler   = handler_mem[c.svc];
          end
        end
      endcase
      pending_words.push_back(w);
    endfunction

    task report_mismatch(input string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    // Compare one shown word with the oldest expected one
    task check_word(input lookup_word_t got);
      lookup_word_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected: %h", got));
        return;
      end
      want = pending_words.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, want %b", got.status, want.status));
      if (got.intercept !== want.intercept)
        report_mismatch($sformatf("intercept %b, want %b", got.intercept, want.intercept));
      if (got.handler !== want.handler)
        report_mismatch($sformatf("handler_out %h, want %h", got.handler, want.handler));
      if (got.service !== want.service)
        report_mismatch($sformatf("matched_service %h, want %h", got.service, want.service));
    endtask
  endclass

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                start_i           = 1'b0;
  logic [1:0]          op_i              = '0;
  logic [SlotW-1:0]    slot_i            = '0;
  logic [HashW-1:0]    key_hash_i        = '0;
  logic [LinkW-1:0]    service_index_i   = '0;
  logic [HandlerW-1:0] handler_word_i    = '0;
  logic                entry_count_we_i  = 1'b0;
  logic [CountW-1:0]   entry_count_i     = '0;
  logic                busy_o;
  logic                done_o;
  logic                status_o;
  logic                intercept_o;
  logic [HandlerW-1:0] handler_out_o;
  logic [LinkW-1:0]    matched_service_o;

  filter_lookup_board board = new;
  int unsigned        burst_left;
  int unsigned        cycle_count;
  int unsigned        random_done;

  hashed_filter_table_lookup_unit #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SERVICE_LIMIT(SERVICE_LIMIT)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .slot_i           (slot_i),
    .key_hash_i       (key_hash_i),
    .service_index_i  (service_index_i),
    .handler_word_i   (handler_word_i),
    .entry_count_we_i (entry_count_we_i),
    .entry_count_i    (entry_count_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .intercept_o      (intercept_o),
    .handler_out_o    (handler_out_o),
    .matched_service_o(matched_service_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Check every shown result word
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      board.check_word({status_o, intercept_o, handler_out_o, matched_service_o});
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic lookup_cmd_t make_cmd(input op_e op, input bit [SlotW-1:0] slot,
                                           input bit [HashW-1:0] key,
                                           input bit [LinkW-1:0] svc,
                                           input bit [HandlerW-1:0] handler);
    lookup_cmd_t c;
    c.op      = op;
    c.slot    = slot;
    c.key     = key;
    c.svc     = svc;
    c.handler = handler;
    return c;
  endfunction

  function automatic bit [LinkW-1:0] pick_link();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return LinkW'($urandom_range(0, SERVICE_LIMIT - 1));
    if (r == 8) return LinkW'($urandom_range(0, 31));
    return LinkW'($urandom_range(SERVICE_LIMIT, 4095));
  endfunction

  // Mostly loaded hashes, some neighbors of them, some anything
  function automatic bit [HashW-1:0] pick_key();
    int r, cnt;
    bit [HashW-1:0] k;
    cnt = board.searched_count();
    r = $urandom_range(0, 99);
    if (cnt > 0 && r < 85) begin
      k = board.key_mem[$urandom_range(0, cnt - 1)];
      if (r >= 65) k = $urandom_range(0, 1) ? k + 1 : k - 1;
      return k;
    end
    return $urandom();
  endfunction

  function automatic bit [LinkW-1:0] pick_service();
    int r, cnt;
    cnt = board.searched_count();
    r = $urandom_range(0, 99);
    if (cnt > 0 && r < 60) return board.link_mem[$urandom_range(0, cnt - 1)];
    if (r < 85) return LinkW'($urandom_range(0, SERVICE_LIMIT - 1));
    return LinkW'($urandom_range(0, 4095));
  endfunction

  // Present one command word in bursts with random gaps; hold until taken
  task automatic send_cmd(input lookup_cmd_t c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      repeat (gap) @(negedge clk_i) start_i <= 1'b0;
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    start_i         <= 1'b1;
    op_i            <= c.op;
    slot_i          <= c.slot;
    key_hash_i      <= c.key;
    service_index_i <= c.svc;
    handler_word_i  <= c.handler;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    board.note_command(c);
  endtask

  // Drop start and wait until every expected word has come and the block is idle
  task automatic settle();
    @(negedge clk_i) start_i <= 1'b0;
    while (board.pending_words.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input bit [CountW-1:0] n);
    settle();
    @(negedge clk_i);
    entry_count_we_i <= 1'b1;
    entry_count_i    <= n;
    @(posedge clk_i) board.entry_count = n;
    @(negedge clk_i) entry_count_we_i <= 1'b0;
  endtask

  // Load slots 0..n-1 with ascending hashes, now and then a repeat
  task automatic load_sorted(input int n);
    longint unsigned k, span;
    span = 64'h1_0000_0000 / (n + 1);
    k = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 32'(span - 1));
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 19) != 0) k += $urandom_range(1, 32'(span));
      if (i == n - 1 && $urandom_range(0, 7) == 0) k = 32'hFFFF_FFFF;
      if (k > 32'hFFFF_FFFF) k = 32'hFFFF_FFFF;
      send_cmd(make_cmd(OP_LOAD, SlotW'(i), k[31:0], pick_link(), $urandom()));
    end
  endtask

  // Searches, dispatches and a little load noise against the current table
  task automatic run_mixed(input int n);
    int r;
    bit [HandlerW-1:0] h;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      h = ($urandom_range(0, 9) == 0) ? '0 : $urandom();
      if (r < 35)
        send_cmd(make_cmd(OP_ENABLE, $urandom(), pick_key(), $urandom(), h));
      else if (r < 55)
        send_cmd(make_cmd(OP_DISABLE, $urandom(), pick_key(), $urandom(), h));
      else if (r < 95)
        send_cmd(make_cmd(OP_DISPATCH, $urandom(), $urandom(), pick_service(), h));
      else
        send_cmd(make_cmd(OP_LOAD, $urandom(), $urandom(), pick_link(), h));
    end
  endtask

  initial begin
    int r, n, m;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    settle();

    // Empty table: every search misses
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'h0, $urandom(), $urandom()));
    send_cmd(make_cmd(OP_DISABLE, $urandom(), 32'hFFFF_FFFF, $urandom(), $urandom()));
    send_cmd(make_cmd(OP_DISPATCH, $urandom(), $urandom(), 12'd0, $urandom()));
    send_cmd(make_cmd(OP_DISPATCH, $urandom(), $urandom(), 12'hFFF, $urandom()));

    // Three entries at the hash extremes, links out of range and at the top
    send_cmd(make_cmd(OP_LOAD, 10'd0, 32'h0, 12'hFFF, $urandom()));
    send_cmd(make_cmd(OP_LOAD, 10'd1, 32'd5, 12'd7, $urandom()));
    send_cmd(make_cmd(OP_LOAD, 10'd2, 32'hFFFF_FFFF, 12'd1023, $urandom()));
    send_cmd(make_cmd(OP_LOAD, 10'd1023, 32'h8000_0000, 12'd1024, $urandom()));
    set_entry_count(11'd3);
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'h0, $urandom(), 32'hFFFF_FFFF));
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'd5, $urandom(), 32'hFFFF_FFFF));
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'hFFFF_FFFF, $urandom(), 32'h0));
    send_cmd(make_cmd(OP_DISPATCH, $urandom(), $urandom(), 12'd7, $urandom()));
    send_cmd(make_cmd(OP_DISPATCH, $urandom(), $urandom(), 12'd1023, $urandom()));
    send_cmd(make_cmd(OP_DISPATCH, $urandom(), $urandom(), 12'd1024, $urandom()));
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'd3, $urandom(), $urandom()));
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'd6, $urandom(), $urandom()));
    send_cmd(make_cmd(OP_DISABLE, $urandom(), 32'd5, $urandom(), $urandom()));
    send_cmd(make_cmd(OP_DISPATCH, $urandom(), $urandom(), 12'd7, $urandom()));
    send_cmd(make_cmd(OP_DISABLE, $urandom(), 32'h0, $urandom(), $urandom()));

    // Single entry: the right bound is the only slot
    set_entry_count(11'd1);
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'h0, $urandom(), $urandom()));
    send_cmd(make_cmd(OP_ENABLE, $urandom(), 32'd5, $urandom(), $urandom()));

    // Zero count again
    set_entry_count(11'd0);
    send_cmd(make_cmd(OP_DISABLE, $urandom(), 32'h0, $urandom(), $urandom()));

    // Fill the whole table once, then search it at a full or clamped count
    load_sorted(TABLE_DEPTH);
    r = $urandom_range(0, 2);
    set_entry_count(r == 0 ? 11'd1024 : (r == 1 ? 11'd1025 : 11'd2047));
    run_mixed(80);
    random_done = 80;

    // Phases: mostly small reloaded tables, now and then empty or full counts
    while (random_done < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        set_entry_count(11'd0);
        m = 20;
      end else if (r == 1) begin
        set_entry_count($urandom_range(0, 1) ? 11'd2047 : CountW'($urandom_range(1024, 2046)));
        m = 40;
      end else begin
        n = $urandom_range(1, 40);
        load_sorted(n);
        set_entry_count(CountW'(n));
        random_done += n;
        m = $urandom_range(20, 50);
      end
      run_mixed(m);
      random_done += m;
    end

    settle();
    repeat (24) @(posedge clk_i);
    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
